/* src/trd_pkg.sv */
// ----------------------------------------------------------------------------
// trd_pkg
// shared types and constants of the tga run-length pixel decoder
// ----------------------------------------------------------------------------
package trd_pkg;

  localparam int BYTE_W     = 8;
  localparam int PIXEL_W    = 32;
  localparam int RUN_W      = 8;
  localparam int PCOUNT_W   = 25;
  localparam int BPP_W      = 3;
  localparam int BPOS_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  localparam logic [BYTE_W-1:0] HDR_SPLIT = 8'd128;
  localparam logic [BYTE_W-1:0] REP_BIAS  = 8'd127;

  localparam logic [BPP_W-1:0] BPP_MIN   = 3'd1;
  localparam logic [BPP_W-1:0] BPP_MAX   = 3'd4;
  localparam logic [BPP_W-1:0] BPP_RESET = 3'd3;

  localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 25'd1;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT     = 2'd1;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2
  } phase_t;

  // one completed pixel from the packet parser
  typedef struct packed {
    logic               fire;
    logic [RUN_W-1:0]   run;
    logic [PIXEL_W-1:0] value;
  } pix_evt_t;

  // clipped count and status from the pixel counter
  typedef struct packed {
    logic [RUN_W-1:0] cnt;
    logic             done;
    logic             err;
  } cnt_res_t;

endpackage

/* src/trd_parse.sv */
// ----------------------------------------------------------------------------
// trd_parse
// packet header parsing and pixel byte gathering
// ----------------------------------------------------------------------------
module trd_parse (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [trd_pkg::BYTE_W-1:0]    in_byte,
  input  logic                          frame_start,
  input  logic [trd_pkg::BPP_W-1:0]     bpp,
  output trd_pkg::pix_evt_t             evt
);

  trd_pkg::phase_t              phase_r, phase_nxt, ph_cur;
  logic [trd_pkg::RUN_W-1:0]    left_r, left_nxt, left_cur;
  logic [trd_pkg::BPOS_W-1:0]   bpos_r, bpos_nxt, bpos_cur;
  logic [trd_pkg::PIXEL_W-1:0]  gather_r, gather_nxt, gather_cur, gather;
  logic [trd_pkg::BPP_W-1:0]    eff_bpp;
  logic                         last_byte;

  // frame start clears state before the byte is taken
  always_comb begin
    ph_cur     = frame_start ? trd_pkg::PH_HEADER : phase_r;
    left_cur   = frame_start ? '0 : left_r;
    bpos_cur   = frame_start ? '0 : bpos_r;
    gather_cur = frame_start ? '0 : gather_r;
  end

  always_comb begin
    if (bpp < trd_pkg::BPP_MIN) begin
      eff_bpp = trd_pkg::BPP_MIN;
    end else if (bpp > trd_pkg::BPP_MAX) begin
      eff_bpp = trd_pkg::BPP_MAX;
    end else begin
      eff_bpp = bpp;
    end
  end

  assign last_byte = ({1'b0, bpos_cur} + 3'd1) >= eff_bpp;
  assign gather = ((bpos_cur == '0) ? '0 : gather_cur)
                | ({24'b0, in_byte} << {bpos_cur, 3'b000});

  // next phase
  always_comb begin
    phase_nxt = ph_cur;
    case (ph_cur)
      trd_pkg::PH_LITERAL: begin
        if (last_byte && left_cur == 8'd1) phase_nxt = trd_pkg::PH_HEADER;
      end
      trd_pkg::PH_REPEAT: begin
        if (last_byte) phase_nxt = trd_pkg::PH_HEADER;
      end
      default: begin
        phase_nxt = (in_byte < trd_pkg::HDR_SPLIT) ? trd_pkg::PH_LITERAL
                                                   : trd_pkg::PH_REPEAT;
      end
    endcase
  end

  // datapath and pixel event
  always_comb begin
    left_nxt   = left_cur;
    bpos_nxt   = bpos_cur;
    gather_nxt = gather;
    evt.fire   = 1'b0;
    evt.run    = 8'd1;
    evt.value  = gather;
    case (ph_cur)
      trd_pkg::PH_LITERAL, trd_pkg::PH_REPEAT: begin
        if (last_byte) begin
          bpos_nxt = '0;
          evt.fire = 1'b1;
          if (ph_cur == trd_pkg::PH_LITERAL) begin
            left_nxt = left_cur - 8'd1;
            evt.run  = 8'd1;
          end else begin
            left_nxt = '0;
            evt.run  = left_cur;
          end
        end else begin
          bpos_nxt = bpos_cur + 2'd1;
        end
      end
      default: begin
        left_nxt   = (in_byte < trd_pkg::HDR_SPLIT) ? in_byte + 8'd1
                                                    : in_byte - trd_pkg::REP_BIAS;
        bpos_nxt   = '0;
        gather_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= trd_pkg::PH_HEADER;
      left_r   <= '0;
      bpos_r   <= '0;
      gather_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      left_r   <= left_nxt;
      bpos_r   <= bpos_nxt;
      gather_r <= gather_nxt;
    end
  end

endmodule

/* src/trd_count.sv */
// ----------------------------------------------------------------------------
// trd_count
// running pixel total, clipping against the image size, sticky overflow
// ----------------------------------------------------------------------------
module trd_count (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          frame_start,
  input  trd_pkg::pix_evt_t             evt,
  input  logic [trd_pkg::PCOUNT_W-1:0]  pixel_count,
  output trd_pkg::cnt_res_t             res
);

  logic [trd_pkg::PCOUNT_W-1:0] done_r, done_nxt, done_cur, remaining, total;
  logic                         err_r, err_nxt, err_cur;
  logic [trd_pkg::RUN_W-1:0]    cnt;

  assign done_cur = frame_start ? '0 : done_r;
  assign err_cur  = frame_start ? 1'b0 : err_r;

  assign remaining = (done_cur >= pixel_count) ? '0 : pixel_count - done_cur;
  assign cnt = ({17'b0, evt.run} < remaining) ? evt.run
                                              : remaining[trd_pkg::RUN_W-1:0];
  assign total = done_cur + {17'b0, cnt};

  always_comb begin
    err_nxt  = err_cur | (evt.fire && cnt != evt.run);
    done_nxt = evt.fire ? total : done_cur;
    res.cnt  = cnt;
    res.done = (cnt != '0) && (total == pixel_count);
    res.err  = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
      err_r  <= 1'b0;
    end else if (step) begin
      done_r <= done_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

/* src/tga_rle_pixel_decoder.sv */
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// run-length pixel stream decoder, one stream byte per item
// ----------------------------------------------------------------------------
// usage
//   in channel  : in_valid/in_ready, one stream byte per item plus
//                 in_frame_start, set on the first packet header of an image
//   out channel : out_valid/out_ready, one item per completed pixel with its
//                 value, repeat count (1 for literal pixels, run length for
//                 repeat pixels), image done and sticky overflow flags
//   cfg channel : cfg_valid/cfg_ready, always ready; index 0 bytes per pixel,
//                 index 1 pixel count; write only while the block is idle
// timing
//   an item sits one cycle in the input register, its result is loaded into
//   the output register at the next edge: out_valid rises one cycle after
//   accept, and the result can be taken at the second edge after accept
//   one item per cycle sustained; the single state update between input and
//   output register sets that figure
// reset and stall
//   synchronous active-low reset empties both registers and returns the
//   parser to expecting a packet header; bytes per pixel resets to 3 and
//   pixel count to 1
//   while a result waits, items that yield no pixel still pass; a pixel item
//   holds in the input register and in_ready drops until out_ready
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [trd_pkg::BYTE_W-1:0]      in_byte,
  input  logic                            in_frame_start,
  // results
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [trd_pkg::PIXEL_W-1:0]     out_pixel_value,
  output logic [trd_pkg::RUN_W-1:0]       out_repeat_count,
  output logic                            out_image_done,
  output logic                            out_overflow_error,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [trd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [trd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic [trd_pkg::BPP_W-1:0]    bpp_r;
  logic [trd_pkg::PCOUNT_W-1:0] pcount_r;

  // input register
  logic                         s1_valid_r, s1_valid_nxt;
  logic [trd_pkg::BYTE_W-1:0]   s1_byte_r;
  logic                         s1_fs_r;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic [trd_pkg::PIXEL_W-1:0]  pixel_r;
  logic [trd_pkg::RUN_W-1:0]    count_r;
  logic                         done_r;
  logic                         err_r;

  trd_pkg::pix_evt_t            evt;
  trd_pkg::cnt_res_t            res;
  logic                         advance;
  logic                         in_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r    <= trd_pkg::BPP_RESET;
      pcount_r <= trd_pkg::PCOUNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        trd_pkg::CFG_BYTES_PER_PIXEL: bpp_r    <= cfg_data[trd_pkg::BPP_W-1:0];
        trd_pkg::CFG_PIXEL_COUNT:     pcount_r <= cfg_data[trd_pkg::PCOUNT_W-1:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  // the held item moves on unless it makes a pixel and the output is blocked
  assign advance  = s1_valid_r && (!evt.fire || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_take  = in_valid && in_ready;

  assign s1_valid_nxt = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_byte;
      s1_fs_r   <= in_frame_start;
    end
  end

  trd_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .in_byte     (s1_byte_r),
    .frame_start (s1_fs_r),
    .bpp         (bpp_r),
    .evt         (evt)
  );

  trd_count u_count (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .frame_start (s1_fs_r),
    .evt         (evt),
    .pixel_count (pcount_r),
    .res         (res)
  );

  // result register, refilled in the same cycle it is taken
  assign out_valid_nxt = (advance && evt.fire) ? 1'b1
                       : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && evt.fire) begin
      pixel_r <= evt.value;
      count_r <= res.cnt;
      done_r  <= res.done;
      err_r   <= res.err;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pixel_value    = pixel_r;
  assign out_repeat_count   = count_r;
  assign out_image_done     = done_r;
  assign out_overflow_error = err_r;

endmodule

/* src/trd_checker.sv */
// ----------------------------------------------------------------------------
// trd_checker
// port-level checks of the tga run-length pixel decoder
// ----------------------------------------------------------------------------
module trd_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [trd_pkg::PIXEL_W-1:0]   out_pixel_value,
  input  logic [trd_pkg::RUN_W-1:0]     out_repeat_count,
  input  logic                          out_image_done,
  input  logic                          out_overflow_error
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_value)
      && $stable(out_repeat_count) && $stable(out_image_done)
      && $stable(out_overflow_error))
    else $error("result changed while stalled");

  // completion always carries at least one pixel
  a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_done |-> out_repeat_count != '0)
    else $error("image done with zero count");

  // a fully clipped pixel must raise the error
  a_clip_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_repeat_count == '0 |-> out_overflow_error)
    else $error("zero count without overflow error");

  // a run never exceeds the longest packet
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_repeat_count <= 8'd128)
    else $error("repeat count above packet limit");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tga_rle_pixel_decoder trd_checker u_trd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_pixel_value    (out_pixel_value),
  .out_repeat_count   (out_repeat_count),
  .out_image_done     (out_image_done),
  .out_overflow_error (out_overflow_error)
);
